FILE: design/lru_erl_pkg.sv
package lru_erl_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned ME_W  = 5;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned IDX_W = 1;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_MAX_ENTRIES    = 1'b0;
  localparam logic [IDX_W-1:0] REG_PRINT_INTERVAL = 1'b1;

  // input op codes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [ME_W-1:0]  MAX_ENTRIES_RST    = 5'd16;
  localparam logic [CNT_W-1:0] PRINT_INTERVAL_RST = 32'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  // one table entry as it moves down the chain
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  // control shared by every cell
  typedef struct packed {
    logic cmp;
    logic upd;
    logic clear;
    logic hit;
    logic evict;
  } cell_ctl_t;

endpackage

FILE: design/lru_erl_cell.sv
module lru_erl_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lru_erl_pkg::cell_ctl_t        ctl_i,
  input  logic [lru_erl_pkg::KEY_W-1:0] cmp_key_i,
  input  logic [lru_erl_pkg::CNT_W-1:0] ivl_i,
  input  lru_erl_pkg::entry_t           prev_i,
  input  logic                          seen_i,
  output lru_erl_pkg::entry_t           ent_o,
  output logic                          seen_o,
  output logic                          match_o,
  output logic [lru_erl_pkg::CNT_W-1:0] hit_cnt_o
);
  import lru_erl_pkg::*;

  logic             valid_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] cnt_q;
  logic             match_q;
  logic             match_d;
  logic [CNT_W-1:0] nxt_q;
  logic [CNT_W-1:0] nxt_d;
  logic [CNT_W:0]   inc;
  logic             shift;

  always_comb begin
    match_d = valid_q && (key_q == cmp_key_i);
    inc     = {1'b0, cnt_q} + {{CNT_W{1'b0}}, 1'b1};
    // wrap the residue once it reaches the interval
    nxt_d   = (inc >= {1'b0, ivl_i}) ? '0 : inc[CNT_W-1:0];
  end

  // hit: cells up to the matching one take their left neighbor
  // miss: occupied cells move down, the first free one fills unless evicting
  always_comb begin
    if (ctl_i.hit) begin
      shift = !seen_i;
    end else begin
      shift = valid_q || (prev_i.valid && !ctl_i.evict);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctl_i.cmp) begin
        match_q <= match_d;
      end
      if (ctl_i.upd && ctl_i.clear) begin
        valid_q <= 1'b0;
      end else if (ctl_i.upd && shift) begin
        valid_q <= prev_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp) begin
      nxt_q <= nxt_d;
    end
    if (ctl_i.upd && !ctl_i.clear && shift) begin
      key_q <= prev_i.key;
      cnt_q <= prev_i.cnt;
    end
  end

  assign ent_o     = '{valid: valid_q, key: key_q, cnt: cnt_q};
  assign seen_o    = seen_i | match_q;
  assign match_o   = match_q;
  assign hit_cnt_o = match_q ? nxt_q : '0;

endmodule

FILE: design/lru_event_rate_limiter.sv
// Channel   Direction  Handshake              Words
// in        input      in_valid_i/in_stall_o   op_i, hash_key_i
// out       output     out_valid_o/out_stall_i should_pass_o, was_hit_o
// cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// Each word passes through capture, parallel key compare in every cell,
// then the chain shift that moves the entry to the head of the recency row.
// The update waits while a previous result is still held on a stalled output.
// Reset empties the table and sets max_entries to 16, print_interval to 1.
// The entries are kept in recency order: cell 0 is the most recent.
module lru_event_rate_limiter #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [lru_erl_pkg::KEY_W-1:0] hash_key_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          should_pass_o,
  output logic                          was_hit_o,
  input  logic                          cfg_we_i,
  input  logic [lru_erl_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [lru_erl_pkg::CFG_W-1:0] cfg_wdata_i
);
  import lru_erl_pkg::*;

  localparam int unsigned PIDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_e           state_q, state_d;
  logic [ME_W-1:0]  max_entries_q;
  logic [CNT_W-1:0] print_interval_q;
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic             out_valid_q;
  logic             should_pass_q;
  logic             was_hit_q;

  logic             in_stall;
  logic             upd_fire;
  logic             hit;
  logic             evict;
  logic [CNT_W-1:0] ivl_eff;
  logic [CNT_W-1:0] sel_nxt;
  logic [8:0]       me_ext;
  logic [8:0]       capm1_w;
  logic [PIDX_W-1:0] capm1;
  entry_t           head;
  cell_ctl_t        ctl;
  logic             pass_d;

  entry_t           ent     [ENTRIES];
  logic             seen    [ENTRIES];
  logic [CNT_W-1:0] hit_cnt [ENTRIES];
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] match_vec;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q    <= MAX_ENTRIES_RST;
      print_interval_q <= PRINT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_ENTRIES:    max_entries_q    <= cfg_wdata_i[ME_W-1:0];
        REG_PRINT_INTERVAL: print_interval_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ivl_eff = (print_interval_q == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : print_interval_q;

  // index of the last slot under the effective capacity
  always_comb begin
    me_ext = 9'(max_entries_q);
    if (max_entries_q == '0) begin
      capm1_w = '0;
    end else if (me_ext >= 9'(ENTRIES)) begin
      capm1_w = 9'(ENTRIES - 1);
    end else begin
      capm1_w = me_ext - 9'd1;
    end
    capm1 = capm1_w[PIDX_W-1:0];
  end

  // state machine
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   if (upd_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_q != S_IDLE);
    upd_fire = (state_q == S_UPD) && !(out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall) begin
      op_q  <= op_i;
      key_q <= hash_key_i;
    end
  end

  // select the advanced residue of the matching cell
  always_comb begin
    sel_nxt = '0;
    for (int p = 0; p < ENTRIES; p++) begin
      sel_nxt = sel_nxt | hit_cnt[p];
    end
  end

  assign hit   = seen[ENTRIES-1];
  assign evict = valid_vec[capm1];

  always_comb begin
    ctl = '{cmp: (state_q == S_CMP), upd: upd_fire, clear: (op_q == OP_CLEAR),
            hit: hit, evict: evict};
    head.valid = 1'b1;
    head.key   = key_q;
    if (hit) begin
      head.cnt = sel_nxt;
    end else begin
      // a new key starts at one occurrence, already wrapped for an interval of one
      head.cnt = (ivl_eff == {{(CNT_W-1){1'b0}}, 1'b1}) ? '0 : {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    entry_t prev;
    logic   seen_in;
    if (p == 0) begin : g_head
      assign prev    = head;
      assign seen_in = 1'b0;
    end else begin : g_body
      assign prev    = ent[p-1];
      assign seen_in = seen[p-1];
    end

    lru_erl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .cmp_key_i (key_q),
      .ivl_i     (ivl_eff),
      .prev_i    (prev),
      .seen_i    (seen_in),
      .ent_o     (ent[p]),
      .seen_o    (seen[p]),
      .match_o   (match_vec[p]),
      .hit_cnt_o (hit_cnt[p])
    );

    assign valid_vec[p] = ent[p].valid;
  end

  // result word
  always_comb begin
    if (op_q == OP_CLEAR) begin
      pass_d = 1'b0;
    end else if (hit) begin
      pass_d = (sel_nxt == '0);
    end else begin
      pass_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      should_pass_q <= pass_d;
      was_hit_q     <= (op_q != OP_CLEAR) && hit;
    end
  end

  assign in_stall_o    = in_stall;
  assign out_valid_o   = out_valid_q;
  assign should_pass_o = should_pass_q;
  assign was_hit_o     = was_hit_q;

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && (op_q == OP_CLEAR)) |=> (valid_vec == '0))
    else $error("table not empty after clear");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(match_vec))
    else $error("key found in more than one cell");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec & (valid_vec + {{(ENTRIES-1){1'b0}}, 1'b1})) == '0))
    else $error("occupied cells do not form a prefix");

  a_out_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_UPD))
    else $error("result word raised outside update");

endmodule

FILE: verif/lru_event_rate_limiter_tb.sv
module lru_event_rate_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lru_erl_pkg::*;

  localparam int TBL_N = 16;
  localparam int N_DIR = 25;
  localparam int N_PHASE = 10;
  localparam int PHASE_WORDS = 140;

  typedef struct packed {
    logic pass;
    logic hit;
  } verdict_t;

  // one line of the directed sequence: a register write or a word
  typedef struct packed {
    bit               is_reg;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] wdata;
    logic             op;
    logic [KEY_W-1:0] key;
    bit               typed;
    logic             pass;
    logic             hit;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             op_i;
  logic [KEY_W-1:0] hash_key_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             should_pass_o;
  logic             was_hit_o;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  // predictor copy of the table and registers
  logic [KEY_W-1:0] tbl_key [TBL_N];
  logic [CNT_W-1:0] tbl_res [TBL_N];
  int unsigned      tbl_rank [TBL_N];
  bit               tbl_vld [TBL_N];
  logic [ME_W-1:0]  cur_max;
  logic [CNT_W-1:0] cur_ivl;

  verdict_t         pending_verdicts [$];
  logic [KEY_W-1:0] key_pool [$];
  int               mismatch_cnt = 0;
  bit               no_idle = 1'b0;
  dir_row_t         dir_rows [N_DIR];

  int unsigned      phase_max [N_PHASE] = '{16, 2, 0, 31, 1, 5, 16, 8, 3, 16};
  logic [CNT_W-1:0] phase_ivl [N_PHASE] = '{32'd1, 32'd7, 32'd0, 32'd2, 32'hFFFF_FFFF,
                                            32'd3, 32'd5, 32'd2, 32'd1, 32'd4};

  lru_event_rate_limiter #(
    .ENTRIES(TBL_N)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .hash_key_i    (hash_key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .should_pass_o (should_pass_o),
    .was_hit_o     (was_hit_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic dir_row_t row_word(input logic op, input logic [KEY_W-1:0] key);
    return '{1'b0, REG_MAX_ENTRIES, '0, op, key, 1'b0, 1'b0, 1'b0};
  endfunction

  function automatic dir_row_t row_typed(input logic op, input logic [KEY_W-1:0] key,
                                         input logic pass, input logic hit);
    return '{1'b0, REG_MAX_ENTRIES, '0, op, key, 1'b1, pass, hit};
  endfunction

  function automatic dir_row_t row_reg(input logic [IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    return '{1'b1, idx, data, OP_CHECK, '0, 1'b0, 1'b0, 1'b0};
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // work out the verdict of one word and advance the table copy
  function automatic verdict_t limiter_predict(input logic op, input logic [KEY_W-1:0] key);
    verdict_t    v;
    int          hit_slot;
    int          occ;
    int          cap;
    int unsigned r;
    bit          done;
    logic [32:0] ivl;
    logic [32:0] nres;
    hit_slot = -1;
    occ = 0;
    done = 1'b0;
    ivl = (cur_ivl == '0) ? 33'd1 : {1'b0, cur_ivl};
    if (op == OP_CLEAR) begin
      for (int i = 0; i < TBL_N; i++) begin
        tbl_vld[i] = 1'b0;
        tbl_rank[i] = 0;
      end
      v.pass = 1'b0;
      v.hit = 1'b0;
      return v;
    end
    for (int i = 0; i < TBL_N; i++)
      if (hit_slot < 0 && tbl_vld[i] && tbl_key[i] == key) hit_slot = i;
    if (hit_slot >= 0) begin
      r = tbl_rank[hit_slot];
      nres = {1'b0, tbl_res[hit_slot]} + 33'd1;
      // a residue left above a lowered interval wraps here
      if (nres >= ivl) nres = '0;
      tbl_res[hit_slot] = nres[CNT_W-1:0];
      for (int i = 0; i < TBL_N; i++)
        if (tbl_vld[i] && tbl_rank[i] < r) tbl_rank[i]++;
      tbl_rank[hit_slot] = 0;
      v.pass = (nres == '0);
      v.hit = 1'b1;
      return v;
    end
    cap = (cur_max == '0) ? 1 : int'(cur_max);
    if (cap > TBL_N) cap = TBL_N;
    for (int i = 0; i < TBL_N; i++)
      if (tbl_vld[i]) occ++;
    // drop only the least recent entry, even when far over capacity
    if (occ >= cap && occ > 0) begin
      for (int i = 0; i < TBL_N; i++)
        if (!done && tbl_vld[i] && tbl_rank[i] == occ - 1) begin
          tbl_vld[i] = 1'b0;
          done = 1'b1;
        end
    end
    for (int i = 0; i < TBL_N; i++)
      if (tbl_vld[i]) tbl_rank[i]++;
    done = 1'b0;
    for (int i = 0; i < TBL_N; i++)
      if (!done && !tbl_vld[i]) begin
        tbl_vld[i] = 1'b1;
        tbl_key[i] = key;
        tbl_res[i] = (ivl == 33'd1) ? '0 : CNT_W'(1);
        tbl_rank[i] = 0;
        done = 1'b1;
      end
    v.pass = 1'b1;
    v.hit = 1'b0;
    return v;
  endfunction

  // present one word after a random gap and hold it until accepted
  task automatic send_word(input logic op, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = no_idle ? 0 : idle_len();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i <= op;
    hash_key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_ENTRIES) cur_max = data[ME_W-1:0];
    else cur_ivl = data;
  endtask

  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: expected no word, actual should_pass=%0b was_hit=%0b",
                 $time, should_pass_o, was_hit_o);
        mismatch_cnt++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (should_pass_o !== exp_v.pass) begin
          $display("%0t: should_pass expected %0b actual %0b", $time, exp_v.pass,
                   should_pass_o);
          mismatch_cnt++;
        end
        if (was_hit_o !== exp_v.hit) begin
          $display("%0t: was_hit expected %0b actual %0b", $time, exp_v.hit, was_hit_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // output stall: random runs, no new run starts while no_idle is set
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  initial begin
    #1_500_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    verdict_t         v;
    dir_row_t         row;
    logic [KEY_W-1:0] key;
    logic             op;
    int unsigned      r;
    int unsigned      n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_CHECK;
    hash_key_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_MAX_ENTRIES;
    cfg_wdata_i = '0;
    cur_max = MAX_ENTRIES_RST;
    cur_ivl = PRINT_INTERVAL_RST;
    for (int i = 0; i < TBL_N; i++) begin
      tbl_vld[i] = 1'b0;
      tbl_rank[i] = 0;
    end

    dir_rows = '{
      row_typed(OP_CHECK, 64'h0, 1'b1, 1'b0),
      row_typed(OP_CHECK, '1, 1'b1, 1'b0),
      row_typed(OP_CHECK, 64'h0, 1'b1, 1'b1),
      row_typed(OP_CLEAR, 64'h5555_5555_5555_5555, 1'b0, 1'b0),
      row_typed(OP_CHECK, 64'h0, 1'b1, 1'b0),
      row_reg(REG_PRINT_INTERVAL, 32'd0),
      row_typed(OP_CHECK, 64'h0, 1'b1, 1'b1),
      row_reg(REG_PRINT_INTERVAL, 32'd3),
      row_typed(OP_CHECK, 64'h5555_5555_5555_5555, 1'b1, 1'b0),
      row_word(OP_CHECK, 64'h5555_5555_5555_5555),
      row_reg(REG_PRINT_INTERVAL, 32'd2),
      row_word(OP_CHECK, 64'h5555_5555_5555_5555),
      row_reg(REG_MAX_ENTRIES, 32'd0),
      row_typed(OP_CHECK, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0),
      row_word(OP_CHECK, 64'h8000_0000_0000_0001),
      row_word(OP_CHECK, 64'h0),
      row_word(OP_CHECK, 64'h5555_5555_5555_5555),
      row_reg(REG_MAX_ENTRIES, 32'd31),
      row_reg(REG_PRINT_INTERVAL, 32'hFFFF_FFFF),
      row_word(OP_CHECK, 64'hAAAA_AAAA_AAAA_AAAA),
      row_word(OP_CHECK, 64'hAAAA_AAAA_AAAA_AAAA),
      row_typed(OP_CLEAR, 64'h0, 1'b0, 1'b0),
      row_typed(OP_CHECK, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0),
      row_reg(REG_MAX_ENTRIES, 32'hFFFF_FFE2),
      row_word(OP_CHECK, 64'h8000_0000_0000_0001)
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_reg) begin
        write_reg(row.idx, row.wdata);
      end else begin
        send_word(row.op, row.key);
        v = limiter_predict(row.op, row.key);
        if (row.typed) begin
          v.pass = row.pass;
          v.hit = row.hit;
        end
        pending_verdicts.push_back(v);
      end
    end

    for (int p = 0; p < N_PHASE; p++) begin
      // junk above bit 4 of max_entries is dropped by the block
      write_reg(REG_MAX_ENTRIES, {27'($urandom_range(0, 32'h07FF_FFFF)),
                                  5'(phase_max[p])});
      write_reg(REG_PRINT_INTERVAL, phase_ivl[p]);
      no_idle = (p == 3 || p == 7);
      // keep the pool now and then so counts carry across an interval change
      if (p == 0 || key_pool.size() == 0 || $urandom_range(0, 1) == 0) begin
        key_pool.delete();
        n = $urandom_range(2, 24);
        repeat (n) key_pool.push_back(rand_key());
        if ($urandom_range(0, 3) == 0) key_pool[0] = '0;
        if ($urandom_range(0, 3) == 0) key_pool[key_pool.size() - 1] = '1;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        r = $urandom_range(0, 99);
        op = OP_CHECK;
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 2) begin
          op = OP_CLEAR;
          key = rand_key();
        end else if (r >= 92) begin
          key = key ^ (64'd1 << $urandom_range(0, KEY_W - 1));
        end else if (r >= 82) begin
          key = rand_key();
        end
        if ($urandom_range(0, 199) == 0) drain_results();
        send_word(op, key);
        pending_verdicts.push_back(limiter_predict(op, key));
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/lru_erl_pkg.sv
design/lru_erl_cell.sv
design/lru_event_rate_limiter.sv
verif/lru_event_rate_limiter_tb.sv
